// ----- hw/rtl/lbf_pkg.sv -----
// ----------------------------------------------------------------------------
// lbf_pkg
// shared types and constants of the led blink and fade pattern core
// ----------------------------------------------------------------------------
package lbf_pkg;

  // length of one short blink flash in ms
  localparam int unsigned BLINK_MS = 10;

  // pattern periods and blink window starts in ms
  localparam int unsigned PERIOD_MS     = 1000;
  localparam int unsigned QUARTER_MS    = 250;
  localparam int unsigned HALF_MS       = 500;
  localparam int unsigned THREE_QTR_MS  = 750;

  // now_ms / 16 is reduced mod 125, since 2000 = 16 * 125
  localparam int unsigned PHASE_LOW_W   = 4;
  localparam int unsigned RES_MOD       = 125;

  // duty levels
  localparam int unsigned DUTY_W        = 10;
  localparam int unsigned DUTY_FULL     = 1023;
  localparam int unsigned DUTY_HALF     = 511;
  localparam int unsigned DUTY_HALF_LOW = 512;

  // floor(p / 999) = (p * RECIP_999) >> RECIP_SHIFT, exact for p < 2^20
  localparam int unsigned RECIP_999     = 1074817;
  localparam int unsigned RECIP_SHIFT   = 30;

  typedef logic [10:0]       phase_t;  // now_ms mod 2000
  typedef logic [9:0]        pos_t;    // now_ms mod 1000
  typedef logic [DUTY_W-1:0] duty_t;

  typedef enum logic [3:0] {
    MODE_OFF       = 4'd0,
    MODE_ON        = 4'd1,
    MODE_TOGGLE    = 4'd2,
    MODE_BLINK_1HZ = 4'd3,
    MODE_BLINK_2HZ = 4'd4,
    MODE_BLINK_4HZ = 4'd5,
    MODE_FADE_IN   = 4'd6,
    MODE_FADE_OUT  = 4'd7,
    MODE_FADE_IO   = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE         = 2'd0,
    CFG_ACTIVE_LEVEL = 2'd1,
    CFG_DIM          = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic active_level;
    logic dim;
  } drive_cfg_t;

endpackage

// ----- hw/rtl/lbf_phase.sv -----
// ----------------------------------------------------------------------------
// lbf_phase
// reduces the millisecond time to its position in a 2000 ms period
// ----------------------------------------------------------------------------
module lbf_phase (
  input  logic [31:0]          now_i,
  output lbf_pkg::phase_t      phase_o
);

  logic [27:0] blk;
  logic [6:0]  c0, c1, c2, c3;
  logic [12:0] sum;
  logic [7:0]  fold;
  logic [6:0]  rem;

  // 128 = 3 mod 125, so 7-bit chunks weigh 1, 3, 9, 27
  always_comb begin
    blk  = now_i[31:lbf_pkg::PHASE_LOW_W];
    c0   = blk[6:0];
    c1   = blk[13:7];
    c2   = blk[20:14];
    c3   = blk[27:21];
    sum  = 13'(c0) + 13'(c1) * 13'd3 + 13'(c2) * 13'd9 + 13'(c3) * 13'd27;
    fold = 8'(sum[6:0]) + 8'(sum[12:7]) * 8'd3;
    if (fold >= 8'(lbf_pkg::RES_MOD)) begin
      rem = 7'(fold - 8'(lbf_pkg::RES_MOD));
    end else begin
      rem = fold[6:0];
    end
  end

  assign phase_o = {rem, now_i[lbf_pkg::PHASE_LOW_W-1:0]};

endmodule

// ----- hw/rtl/lbf_duty.sv -----
// ----------------------------------------------------------------------------
// lbf_duty
// linear fade duty for one position in a 1000 ms ramp
// ----------------------------------------------------------------------------
module lbf_duty (
  input  lbf_pkg::pos_t       pos_i,
  input  logic                rise_i,
  input  lbf_pkg::drive_cfg_t cfg_i,
  output lbf_pkg::duty_t      duty_o
);

  logic [19:0]          span;
  logic [40:0]          prod;
  lbf_pkg::duty_t       q;

  always_comb begin
    // pos * 511 or pos * 1023
    if (cfg_i.dim) begin
      span = (20'(pos_i) << 9) - 20'(pos_i);
    end else begin
      span = (20'(pos_i) << 10) - 20'(pos_i);
    end
    prod = 41'(span) * 41'(lbf_pkg::RECIP_999);
    q    = prod[lbf_pkg::RECIP_SHIFT +: lbf_pkg::DUTY_W];

    if (rise_i) begin
      duty_o = cfg_i.active_level ? q : ~q;
    end else if (cfg_i.active_level) begin
      duty_o = cfg_i.dim ? lbf_pkg::duty_t'(lbf_pkg::DUTY_HALF) - q
                         : lbf_pkg::duty_t'(lbf_pkg::DUTY_FULL) - q;
    end else begin
      duty_o = cfg_i.dim ? (q | lbf_pkg::duty_t'(lbf_pkg::DUTY_HALF_LOW)) : q;
    end
  end

endmodule

// ----- hw/rtl/led_blink_fade_pattern_core.sv -----
// ----------------------------------------------------------------------------
// led_blink_fade_pattern_core
// led drive pattern generator: steady, toggle, short blinks and pwm fades
// ----------------------------------------------------------------------------
// usage
//   - each item on the s_axis side is an update request: tdata carries the
//     free-running millisecond time, tuser the force flag
//   - each update gives zero or one item on the m_axis side: tuser says
//     whether the pin is pwm driven, tdata holds level, duty and lit flag
//   - steady off and on modes give an item only when force is set; modes
//     above fade in-out give nothing
//   - mode, active level and half bright are written through the cfg port;
//     the user must write only while no update is in flight (unenforced)
//   - an update goes through the input stage, then the output register, to
//     m_axis; one update is taken every cycle while the receiver does not
//     stall; the input stage holds the 20x21 constant fade duty multiply
//   - when the receiver stalls the result waits in the output register;
//     one more update is still taken into the input stage, further ones
//     wait, and updates that give no item always pass
//   - reset clears the lit flag, sets mode off, active level high and
//     half bright off
// ----------------------------------------------------------------------------
module led_blink_fade_pattern_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,

  // update requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
  input  logic        s_axis_tuser,   // [0] force_req

  // drive results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] digital_level, [10:1] pwm_duty,
                                      // [11] lit_flag, [15:12] zero
  output logic        m_axis_tuser    // [0] uses_pwm
);

  // configuration registers
  logic [3:0] mode_q;
  logic       active_q;
  logic       half_q;

  // kept lit flag
  logic       lit_q, lit_d;

  // input stage
  logic              s1_valid_q;
  lbf_pkg::phase_t   s1_phase_q;
  logic              s1_force_q;
  lbf_pkg::phase_t   phase_in;

  // output register
  logic              m_valid_q;
  logic              m_pwm_q, m_level_q, m_lit_q;
  lbf_pkg::duty_t    m_duty_q;

  // result logic
  lbf_pkg::pos_t       pos;
  lbf_pkg::drive_cfg_t dcfg;
  lbf_pkg::duty_t      fade_duty;
  logic                set_on, set_off, fade, fade_rise;
  logic                win_0, win_250, win_500, win_750;
  logic                emit, out_free, s1_adv, s1_fire;
  logic                res_pwm, res_level;
  lbf_pkg::duty_t      res_duty;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lbf_pkg::MODE_OFF;
      active_q <= 1'b1;
      half_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbf_pkg::CFG_MODE:         mode_q   <= cfg_data_i;
        lbf_pkg::CFG_ACTIVE_LEVEL: active_q <= cfg_data_i[0];
        lbf_pkg::CFG_DIM:          half_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // time is reduced to the 2000 ms phase on the way in
  lbf_phase u_phase (
    .now_i   (s_axis_tdata),
    .phase_o (phase_in)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!emit || out_free);
  assign s1_fire       = s1_adv && emit;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_phase_q <= phase_in;
      s1_force_q <= s_axis_tuser;
    end
  end

  // position in the 1000 ms period and the blink windows
  always_comb begin
    if (s1_phase_q >= lbf_pkg::phase_t'(lbf_pkg::PERIOD_MS)) begin
      pos = lbf_pkg::pos_t'(s1_phase_q - lbf_pkg::phase_t'(lbf_pkg::PERIOD_MS));
    end else begin
      pos = s1_phase_q[9:0];
    end
    win_0   = pos < lbf_pkg::pos_t'(lbf_pkg::BLINK_MS);
    win_250 = pos >= lbf_pkg::pos_t'(lbf_pkg::QUARTER_MS) &&
              pos <  lbf_pkg::pos_t'(lbf_pkg::QUARTER_MS + lbf_pkg::BLINK_MS);
    win_500 = pos >= lbf_pkg::pos_t'(lbf_pkg::HALF_MS) &&
              pos <  lbf_pkg::pos_t'(lbf_pkg::HALF_MS + lbf_pkg::BLINK_MS);
    win_750 = pos >= lbf_pkg::pos_t'(lbf_pkg::THREE_QTR_MS) &&
              pos <  lbf_pkg::pos_t'(lbf_pkg::THREE_QTR_MS + lbf_pkg::BLINK_MS);
  end

  assign dcfg.active_level = active_q;
  assign dcfg.dim          = half_q;

  lbf_duty u_duty (
    .pos_i  (pos),
    .rise_i (fade_rise),
    .cfg_i  (dcfg),
    .duty_o (fade_duty)
  );

  // mode decode
  always_comb begin
    set_on    = 1'b0;
    set_off   = 1'b0;
    fade      = 1'b0;
    fade_rise = 1'b0;
    unique case (mode_q)
      lbf_pkg::MODE_OFF:    set_off = 1'b1;
      lbf_pkg::MODE_ON:     set_on  = 1'b1;
      lbf_pkg::MODE_TOGGLE: begin
        set_on  = !lit_q;
        set_off = lit_q;
      end
      lbf_pkg::MODE_BLINK_1HZ: begin
        set_on  = win_0;
        set_off = !win_0;
      end
      lbf_pkg::MODE_BLINK_2HZ: begin
        set_on  = win_0 || win_500;
        set_off = !(win_0 || win_500);
      end
      lbf_pkg::MODE_BLINK_4HZ: begin
        set_on  = win_0 || win_250 || win_500 || win_750;
        set_off = !(win_0 || win_250 || win_500 || win_750);
      end
      lbf_pkg::MODE_FADE_IN: begin
        fade      = 1'b1;
        fade_rise = 1'b1;
      end
      lbf_pkg::MODE_FADE_OUT: fade = 1'b1;
      lbf_pkg::MODE_FADE_IO: begin
        fade      = 1'b1;
        fade_rise = s1_phase_q < lbf_pkg::phase_t'(lbf_pkg::PERIOD_MS);
      end
      default: ;
    endcase
  end

  // steady modes need force to give a result
  assign emit = s1_valid_q && (set_on || set_off || fade) &&
                (s1_force_q || mode_q > lbf_pkg::MODE_ON);

  // drive selection
  always_comb begin
    lit_d     = lit_q;
    res_pwm   = 1'b0;
    res_level = 1'b0;
    res_duty  = '0;
    if (fade) begin
      res_pwm  = 1'b1;
      res_duty = fade_duty;
    end else if (set_on) begin
      lit_d = 1'b1;
      if (half_q) begin
        res_pwm  = 1'b1;
        res_duty = active_q ? lbf_pkg::duty_t'(lbf_pkg::DUTY_HALF)
                            : lbf_pkg::duty_t'(lbf_pkg::DUTY_HALF_LOW);
      end else begin
        res_level = active_q;
      end
    end else if (set_off) begin
      lit_d     = 1'b0;
      res_level = !active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= 1'b0;
    end else if (s1_fire) begin
      lit_q <= lit_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      m_pwm_q   <= res_pwm;
      m_level_q <= res_level;
      m_duty_q  <= res_duty;
      m_lit_q   <= lit_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_pwm_q;
  assign m_axis_tdata  = {4'b0000, m_lit_q, m_duty_q, m_level_q};

  // lit only moves when a result leaves the input stage
  a_lit_change : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lit_q != $past(lit_q)) |-> $past(s1_fire))
    else $error("lit flag changed without a result");

  // digital drive carries no duty, pwm drive no level
  a_drive_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_pwm_q ? !m_level_q : (m_duty_q == '0)))
    else $error("digital and pwm drive mixed");

  // half bright active high never exceeds half duty
  a_half_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && half_q && active_q) |=>
      (m_duty_q <= lbf_pkg::duty_t'(lbf_pkg::DUTY_HALF)))
    else $error("half bright duty above half range");

endmodule
